// File: hw/rtl/f9cs_pkg.sv
// Package for the FAST-9 corner score stream unit.
// Holds the transaction structs, geometry constants, circle tables and codes.
// No dependencies; every RTL file of the block refers to it by scoped names.
`default_nettype none

package f9cs_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_LIMIT = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int LINES = 6;
    localparam int WIN = 7;
    localparam int CIRCLE = 16;
    localparam int RUN_MIN = 9;
    localparam int MARGIN = 4;
    localparam int CTR_OFFSET = 3;

    localparam int LB_DEPTH = MAX_WIDTH;
    localparam int LB_AW = $clog2(MAX_WIDTH);
    localparam int LINE_W = $clog2(LINES);

    localparam logic [7:0] THRESHOLD_RST = 8'd22;
    localparam logic [10:0] WIDTH_RST = 11'd720;
    localparam logic [10:0] HEIGHT_RST = 11'd540;

    localparam int CIRC_R [CIRCLE] = '{0, 0, 1, 2, 3, 4, 5, 6, 6, 6, 5, 4, 3, 2, 1, 0};
    localparam int CIRC_C [CIRCLE] = '{3, 4, 5, 6, 6, 6, 5, 4, 3, 2, 1, 0, 0, 0, 1, 2};

    typedef enum logic [1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_WIDTH     = 2'd1,
        CFG_HEIGHT    = 2'd2
    } t_cfg_idx;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_BRIGHT = 2'd1;
    localparam logic [1:0] KIND_DARK = 2'd2;

    typedef logic [7:0] t_pixel;
    typedef logic [LB_AW-1:0] t_lb_addr;
    typedef logic [LINE_W-1:0] t_line;
    typedef logic [LINES-1:0][7:0] t_lines;
    typedef logic [WIN-1:0][WIN-1:0][7:0] t_window;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_start;
    } t_in;

    typedef struct packed {
        logic        valid_res;
        logic [9:0]  center_col;
        logic [9:0]  center_row;
        logic [1:0]  corner_kind;
        logic [11:0] score;
    } t_out;

    typedef struct packed {
        logic       valid_res;
        logic [9:0] center_col;
        logic [9:0] center_row;
    } t_meta;

    function automatic t_line line_rot(t_line base, int unsigned k);
        logic [LINE_W:0] s;
        s = {1'b0, base} + (LINE_W + 1)'(k);
        if (s >= (LINE_W + 1)'(LINES)) begin
            s = s - (LINE_W + 1)'(LINES);
        end
        return t_line'(s);
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fast9_corner_score_stream_unit.sv
// Top level of the FAST-9 corner score stream unit.
// Holds the pixel counters, configuration, 7x7 window and the pipeline control.
// Depends on f9cs_pkg, f9cs_line_buf and f9cs_score.
//
// Usage:
// Grey pixels enter in raster order on the i_pix channel (valid and ready); a
// transaction with frame_start set places its pixel at row 0, column 0.
// Every accepted pixel gives exactly one result transaction on the o_res
// channel for the centre three rows up and three columns back, in order.
// The pipeline has four register stages: line buffer read, window shift,
// circle classification with difference sums, and run detection into the
// output register. One pixel per cycle is sustained while the receiver is
// ready, limited by the single read and write port of each line buffer bank.
// Each stage holds its contents while the next one is full and cannot move on,
// so a stalled receiver backs up the pipeline stage by stage before o_pix_ready falls.
// Reset clears the counters and the pipeline and loads the default threshold,
// width and height. Line buffer contents are undefined until written.
// Configuration writes through i_cfg_we take effect at once; the user must make
// them only while no transaction is in flight, which the block does not enforce.
`default_nettype none

module fast9_corner_score_stream_unit (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_pix_valid,
    output logic                 o_pix_ready,
    input  wire f9cs_pkg::t_in   i_pix,
    output logic                 o_res_valid,
    input  wire logic            i_res_ready,
    output f9cs_pkg::t_out       o_res,
    input  wire logic            i_cfg_we,
    input  wire logic [1:0]      i_cfg_idx,
    input  wire logic [10:0]     i_cfg_data
);

    logic [7:0] r_thr;
    logic [10:0] r_width;
    logic [10:0] r_height;

    logic [9:0] r_col, n_col;
    logic [9:0] r_row, n_row;
    f9cs_pkg::t_line r_line, n_line;

    logic [9:0] cur_col;
    logic [9:0] cur_row;
    f9cs_pkg::t_line cur_line;
    logic [10:0] w_eff;
    logic [10:0] col_p1;
    logic [10:0] row_p1;
    f9cs_pkg::t_meta n_meta;

    logic accept;
    logic en1;
    logic en2;
    logic sc_ready;

    logic r_s1_v;
    f9cs_pkg::t_pixel r_s1_pix;
    f9cs_pkg::t_line r_s1_line;
    f9cs_pkg::t_meta r_s1_meta;
    f9cs_pkg::t_lines rd_data;

    logic r_s2_v;
    f9cs_pkg::t_window r_win, n_win;
    f9cs_pkg::t_meta r_s2_meta;

    assign en2 = !r_s2_v || sc_ready;
    assign en1 = !r_s1_v || en2;
    assign o_pix_ready = en1;
    assign accept = i_pix_valid && en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= f9cs_pkg::THRESHOLD_RST;
            r_width <= f9cs_pkg::WIDTH_RST;
            r_height <= f9cs_pkg::HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                f9cs_pkg::CFG_THRESHOLD: r_thr <= i_cfg_data[7:0];
                f9cs_pkg::CFG_WIDTH: r_width <= i_cfg_data;
                f9cs_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        cur_col = i_pix.frame_start ? '0 : r_col;
        cur_row = i_pix.frame_start ? '0 : r_row;
        cur_line = i_pix.frame_start ? '0 : r_line;

        if (r_width > 11'(f9cs_pkg::COL_LIMIT)) begin
            w_eff = 11'(f9cs_pkg::COL_LIMIT);
        end else if (r_width == '0) begin
            w_eff = 11'd1;
        end else begin
            w_eff = r_width;
        end

        col_p1 = {1'b0, cur_col} + 11'd1;
        row_p1 = {1'b0, cur_row} + 11'd1;

        n_meta.valid_res = (cur_row >= 10'(f9cs_pkg::MARGIN + f9cs_pkg::CTR_OFFSET))
            && (cur_col >= 10'(f9cs_pkg::MARGIN + f9cs_pkg::CTR_OFFSET))
            && (row_p1 < r_height) && (col_p1 < w_eff);
        n_meta.center_col = cur_col - 10'(f9cs_pkg::CTR_OFFSET);
        n_meta.center_row = cur_row - 10'(f9cs_pkg::CTR_OFFSET);

        if (col_p1 >= w_eff) begin
            n_col = '0;
            n_row = cur_row + 10'd1;
            if (cur_row == '1 || cur_line == f9cs_pkg::t_line'(f9cs_pkg::LINES - 1)) begin
                n_line = '0;
            end else begin
                n_line = cur_line + f9cs_pkg::t_line'(1);
            end
        end else begin
            n_col = col_p1[9:0];
            n_row = cur_row;
            n_line = cur_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_line <= '0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
                r_line <= n_line;
            end
            if (en1) begin
                r_s1_v <= i_pix_valid;
            end
            if (en2) begin
                r_s2_v <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix <= i_pix.pixel;
            r_s1_line <= cur_line;
            r_s1_meta <= n_meta;
        end
        if (en2 && r_s1_v) begin
            r_win <= n_win;
            r_s2_meta <= r_s1_meta;
        end
    end

    f9cs_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_en      (accept),
        .i_addr    (f9cs_pkg::t_lb_addr'(cur_col)),
        .i_wr_line (cur_line),
        .i_wr_data (i_pix.pixel),
        .o_rd_data (rd_data)
    );

    always_comb begin
        for (int k = 0; k < f9cs_pkg::WIN; k++) begin
            for (int j = 0; j < f9cs_pkg::WIN - 1; j++) begin
                n_win[k][j] = r_win[k][j+1];
            end
        end
        for (int k = 0; k < f9cs_pkg::LINES; k++) begin
            n_win[k][f9cs_pkg::WIN-1] = rd_data[f9cs_pkg::line_rot(r_s1_line, k)];
        end
        n_win[f9cs_pkg::WIN-1][f9cs_pkg::WIN-1] = r_s1_pix;
    end

    f9cs_score u_score (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_v),
        .o_ready (sc_ready),
        .i_win   (r_win),
        .i_meta  (r_s2_meta),
        .i_thr   (r_thr),
        .o_valid (o_res_valid),
        .i_ready (i_res_ready),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

// File: hw/rtl/f9cs_line_buf.sv
// Line buffer of the FAST-9 corner score stream unit: one memory bank per line.
// Every bank is read at the current column; the bank of the current line is written.
// Depends on f9cs_pkg.
`default_nettype none

module f9cs_line_buf (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire f9cs_pkg::t_lb_addr i_addr,
    input  wire f9cs_pkg::t_line    i_wr_line,
    input  wire f9cs_pkg::t_pixel   i_wr_data,
    output wire f9cs_pkg::t_lines   o_rd_data
);

    for (genvar b = 0; b < f9cs_pkg::LINES; b++) begin : g_bank
        logic [7:0] r_mem [f9cs_pkg::LB_DEPTH];
        logic [7:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rd <= r_mem[i_addr];
                if (i_wr_line == f9cs_pkg::t_line'(b)) begin
                    r_mem[i_addr] <= i_wr_data;
                end
            end
        end

        assign o_rd_data[b] = r_rd;
    end

endmodule

`default_nettype wire

// File: hw/rtl/f9cs_score.sv
// Corner classification and scoring stages of the FAST-9 corner score stream unit.
// Classifies the circle, sums the differences, then detects the contiguous run.
// Depends on f9cs_pkg.
`default_nettype none

module f9cs_score (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire f9cs_pkg::t_window i_win,
    input  wire f9cs_pkg::t_meta   i_meta,
    input  wire logic [7:0]        i_thr,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output f9cs_pkg::t_out         o_res
);

    localparam int N = f9cs_pkg::CIRCLE;

    function automatic logic has_run(logic [N-1:0] m);
        logic [2*N-1:0] d;
        logic f;
        d = {m, m};
        f = 1'b0;
        for (int s = 0; s < N; s++) begin
            f = f | (&d[s +: f9cs_pkg::RUN_MIN]);
        end
        return f;
    endfunction

    logic r_a_v;
    logic r_o_v;
    logic en_a;
    logic en_o;

    logic [N-1:0] n_bm, n_dm;
    logic [11:0] n_bsum, n_dsum;
    logic [N-1:0] r_bm, r_dm;
    logic [11:0] r_bsum, r_dsum;
    f9cs_pkg::t_meta r_a_meta;
    f9cs_pkg::t_out r_res;
    f9cs_pkg::t_out n_res;

    logic [7:0] centre;
    logic [7:0] v;
    logic [7:0] bd [N];
    logic [7:0] dd [N];
    logic [8:0] b1 [N/2];
    logic [8:0] d1 [N/2];
    logic [9:0] b2 [N/4];
    logic [9:0] d2 [N/4];
    logic [10:0] b3 [N/8];
    logic [10:0] d3 [N/8];

    assign en_o = !r_o_v || i_ready;
    assign en_a = !r_a_v || en_o;
    assign o_ready = en_a;
    assign o_valid = r_o_v;
    assign o_res = r_res;

    always_comb begin
        centre = i_win[f9cs_pkg::CTR_OFFSET][f9cs_pkg::CTR_OFFSET];
        v = '0;
        for (int i = 0; i < N; i++) begin
            v = i_win[f9cs_pkg::CIRC_R[i]][f9cs_pkg::CIRC_C[i]];
            n_bm[i] = i_meta.valid_res && ({1'b0, v} > ({1'b0, centre} + {1'b0, i_thr}));
            n_dm[i] = i_meta.valid_res && (({1'b0, v} + {1'b0, i_thr}) < {1'b0, centre});
            bd[i] = n_bm[i] ? (v - centre) : 8'd0;
            dd[i] = n_dm[i] ? (centre - v) : 8'd0;
        end
        for (int i = 0; i < N / 2; i++) begin
            b1[i] = {1'b0, bd[2*i]} + {1'b0, bd[2*i+1]};
            d1[i] = {1'b0, dd[2*i]} + {1'b0, dd[2*i+1]};
        end
        for (int i = 0; i < N / 4; i++) begin
            b2[i] = {1'b0, b1[2*i]} + {1'b0, b1[2*i+1]};
            d2[i] = {1'b0, d1[2*i]} + {1'b0, d1[2*i+1]};
        end
        for (int i = 0; i < N / 8; i++) begin
            b3[i] = {1'b0, b2[2*i]} + {1'b0, b2[2*i+1]};
            d3[i] = {1'b0, d2[2*i]} + {1'b0, d2[2*i+1]};
        end
        n_bsum = {1'b0, b3[0]} + {1'b0, b3[1]};
        n_dsum = {1'b0, d3[0]} + {1'b0, d3[1]};
    end

    always_comb begin
        n_res.valid_res = r_a_meta.valid_res;
        n_res.center_col = r_a_meta.center_col;
        n_res.center_row = r_a_meta.center_row;
        if (has_run(r_bm)) begin
            n_res.corner_kind = f9cs_pkg::KIND_BRIGHT;
            n_res.score = r_bsum;
        end else if (has_run(r_dm)) begin
            n_res.corner_kind = f9cs_pkg::KIND_DARK;
            n_res.score = r_dsum;
        end else begin
            n_res.corner_kind = f9cs_pkg::KIND_NONE;
            n_res.score = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_v <= i_valid;
            end
            if (en_o) begin
                r_o_v <= r_a_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && i_valid) begin
            r_bm <= n_bm;
            r_dm <= n_dm;
            r_bsum <= n_bsum;
            r_dsum <= n_dsum;
            r_a_meta <= i_meta;
        end
        if (en_o && r_a_v) begin
            r_res <= n_res;
        end
    end

endmodule

`default_nettype wire

// File: bench/tb_fast9_corner_score_stream_unit.sv
// Self-checking bench for fast9_corner_score_stream_unit: streams synthetic frames and
// compares each result transaction with a cycle-free FAST-9 corner predictor.
// Depends on f9cs_pkg and the RTL of the unit; needs no files or arguments.
`timescale 1ns / 100ps

module tb_fast9_corner_score_stream_unit;

    localparam int LINE_LEN = f9cs_pkg::MAX_WIDTH;
    localparam int COL_CAP = (LINE_LEN < 1024) ? LINE_LEN : 1024;
    localparam int LINE_SLOTS = 6;
    localparam int BORDER = 4;
    localparam int CTR_LAG = 3;
    localparam int RANDOM_PIXELS = 90;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;
    localparam int PRINT_CAP = 40;
    localparam int MAX_RECTS = 16;

    localparam int RING_ROW [16] = '{0, 0, 1, 2, 3, 4, 5, 6, 6, 6, 5, 4, 3, 2, 1, 0};
    localparam int RING_COL [16] = '{3, 4, 5, 6, 6, 6, 5, 4, 3, 2, 1, 0, 0, 0, 1, 2};

    typedef enum int {
        PACE_OPEN,
        PACE_HALF,
        PACE_SPARSE,
        PACE_BEAT
    } t_pace;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic pix_valid = 1'b0;
    logic pix_ready;
    f9cs_pkg::t_in pix_data = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    f9cs_pkg::t_out res_data;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_idx = f9cs_pkg::CFG_THRESHOLD;
    logic [10:0] cfg_data = '0;

    f9cs_pkg::t_in pixel_backlog[$];
    f9cs_pkg::t_out corner_expected[$];

    logic [7:0] thr = 8'd22;
    logic [10:0] img_w = 11'd720;
    logic [10:0] img_h = 11'd540;
    logic [7:0] line_mem [LINE_SLOTS*LINE_LEN];
    logic [7:0] win [7][7];
    int col_pos = 0;
    int row_pos = 0;

    int scene_bg;
    int scene_jitter;
    bit scene_noise_only;
    int rect_count;
    int rect_r [MAX_RECTS];
    int rect_c [MAX_RECTS];
    int rect_h [MAX_RECTS];
    int rect_w [MAX_RECTS];
    int rect_level [MAX_RECTS];

    int pix_count = 0;
    int gap_left = 0;
    int burst_left = 16;
    int hold_left = 0;
    int hold_mark = 150;
    int pace_tick = 0;
    t_pace pace_mode = PACE_OPEN;
    int quiet = 0;
    int mismatches = 0;
    int margin_seen = 0;
    int bright_seen = 0;
    int dark_seen = 0;
    int settings_used = 0;

    fast9_corner_score_stream_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_pix_valid (pix_valid),
        .o_pix_ready (pix_ready),
        .i_pix       (pix_data),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic run_of_nine(input logic [15:0] map);
        logic [31:0] twice;
        logic found;
        int s;
        twice = {map, map};
        found = 1'b0;
        for (s = 0; s < 16; s++) begin
            if (&twice[s +: 9]) begin
                found = 1'b1;
            end
        end
        return found;
    endfunction

    task automatic corner_predict(input f9cs_pkg::t_in px);
        int eff_w, c, r, cr, cc, centre, v, k, j, thr_i, bright_sum, dark_sum;
        logic [15:0] bright_map, dark_map;
        logic in_margin;
        f9cs_pkg::t_out res;
        bright_sum = 0;
        dark_sum = 0;
        bright_map = '0;
        dark_map = '0;
        thr_i = thr;
        if (px.frame_start) begin
            col_pos = 0;
            row_pos = 0;
        end
        eff_w = img_w;
        if (eff_w > COL_CAP) begin
            eff_w = COL_CAP;
        end
        if (eff_w == 0) begin
            eff_w = 1;
        end
        c = col_pos % COL_CAP;
        r = row_pos % 1024;
        for (k = 0; k < 7; k++) begin
            for (j = 0; j < 6; j++) begin
                win[k][j] = win[k][j+1];
            end
        end
        for (k = 0; k < LINE_SLOTS; k++) begin
            win[k][6] = line_mem[((r + k) % LINE_SLOTS) * LINE_LEN + c];
        end
        win[6][6] = px.pixel;
        line_mem[(r % LINE_SLOTS) * LINE_LEN + c] = px.pixel;
        cr = r - CTR_LAG;
        cc = c - CTR_LAG;
        in_margin = (cr >= BORDER) && (cc >= BORDER) && (cr + BORDER < int'(img_h))
            && (cc + BORDER < eff_w);
        res = '0;
        res.valid_res = in_margin;
        res.center_col = 10'(c - CTR_LAG);
        res.center_row = 10'(r - CTR_LAG);
        if (in_margin) begin
            centre = win[3][3];
            for (k = 0; k < 16; k++) begin
                v = win[RING_ROW[k]][RING_COL[k]];
                if (v > centre + thr_i) begin
                    bright_map[k] = 1'b1;
                    bright_sum += v - centre;
                end else if (v < centre - thr_i) begin
                    dark_map[k] = 1'b1;
                    dark_sum += centre - v;
                end
            end
            if (run_of_nine(bright_map)) begin
                res.corner_kind = f9cs_pkg::KIND_BRIGHT;
                res.score = 12'(bright_sum);
            end else if (run_of_nine(dark_map)) begin
                res.corner_kind = f9cs_pkg::KIND_DARK;
                res.score = 12'(dark_sum);
            end
        end
        corner_expected = {corner_expected, res};
        if (c + 1 >= eff_w) begin
            col_pos = 0;
            row_pos = (r + 1) % 1024;
        end else begin
            col_pos = c + 1;
        end
    endtask

    function automatic int scene_value(input int r, input int c);
        int v, i;
        if (scene_noise_only) begin
            return int'($urandom_range(0, 255));
        end
        v = scene_bg;
        for (i = 0; i < rect_count; i++) begin
            if (r >= rect_r[i] && r < rect_r[i] + rect_h[i] &&
                c >= rect_c[i] && c < rect_c[i] + rect_w[i]) begin
                v = rect_level[i];
            end
        end
        if (scene_jitter > 0) begin
            v = v + int'($urandom_range(0, 2 * scene_jitter)) - scene_jitter;
        end
        if (v < 0) begin
            v = 0;
        end
        if (v > 255) begin
            v = 255;
        end
        return v;
    endfunction

    task automatic new_scene(input int bg, input int jitter, input bit noise_only);
        scene_bg = bg;
        scene_jitter = jitter;
        scene_noise_only = noise_only;
        rect_count = 0;
    endtask

    task automatic add_rect(input int r, c, h, w, level);
        rect_r[rect_count] = r;
        rect_c[rect_count] = c;
        rect_h[rect_count] = h;
        rect_w[rect_count] = w;
        rect_level[rect_count] = level;
        rect_count++;
    endtask

    function automatic int pick_level();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 255;
            default: return int'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic random_scene(input int w, input int h, input int max_rects);
        int n, i;
        new_scene(pick_level(), int'($urandom_range(0, 3)), 1'b0);
        n = $urandom_range(1, max_rects);
        for (i = 0; i < n; i++) begin
            add_rect($urandom_range(0, h - 1), $urandom_range(0, w - 1),
                $urandom_range(1, 6), $urandom_range(1, 6), pick_level());
        end
    endtask

    task automatic queue_pixels(input int r0, c0, line_w, count, input bit fresh);
        f9cs_pkg::t_in item;
        int r, c, i;
        r = r0;
        c = c0;
        for (i = 0; i < count; i++) begin
            item.pixel = 8'(scene_value(r, c));
            item.frame_start = fresh && (i == 0);
            pixel_backlog = {pixel_backlog, item};
            c++;
            if (c >= line_w) begin
                c = 0;
                r++;
            end
        end
    endtask

    task automatic write_reg(input f9cs_pkg::t_cfg_idx idx, input logic [10:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        case (idx)
            f9cs_pkg::CFG_THRESHOLD: thr = value[7:0];
            f9cs_pkg::CFG_WIDTH: img_w = value;
            default: img_h = value;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(input int t, input int w, input int h);
        write_reg(f9cs_pkg::CFG_THRESHOLD, 11'(t));
        write_reg(f9cs_pkg::CFG_WIDTH, 11'(w));
        write_reg(f9cs_pkg::CFG_HEIGHT, 11'(h));
        end_writes();
        settings_used++;
    endtask

    task automatic settle();
        while (pixel_backlog.size() != 0 || pix_valid || corner_expected.size() != 0) begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic compare_field(input string name, input logic [11:0] want,
                                 input logic [11:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= PRINT_CAP) begin
                $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            end
        end
    endtask

    always @(posedge clk) begin : drive_pixels
        logic next_valid;
        f9cs_pkg::t_in next_pix;
        next_valid = pix_valid;
        next_pix = pix_data;
        if (!rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (pix_valid && pix_ready) begin
                corner_predict(pix_data);
                pix_count <= pix_count + 1;
                next_valid = 1'b0;
            end
            if (!next_valid && pixel_backlog.size() != 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    next_pix = pixel_backlog.pop_front();
                    next_valid = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 48);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
        pix_valid <= next_valid;
        pix_data <= next_pix;
    end

    always @(posedge clk) begin : pace_results
        if (!rst_n) begin
            res_ready <= 1'b0;
        end else begin
            pace_tick++;
            if (pace_tick % 64 == 0) begin
                pace_mode = t_pace'($urandom_range(0, 3));
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ready <= 1'b0;
            end else if (pix_count >= hold_mark) begin
                hold_left = HOLD_CYCLES;
                hold_mark += 4000;
                res_ready <= 1'b0;
            end else begin
                case (pace_mode)
                    PACE_OPEN: res_ready <= 1'b1;
                    PACE_HALF: res_ready <= ($urandom_range(0, 1) == 0);
                    PACE_SPARSE: res_ready <= ($urandom_range(0, 3) == 0);
                    default: res_ready <= ((pace_tick & 4) != 0);
                endcase
            end
        end
    end

    always @(posedge clk) begin : check_results
        f9cs_pkg::t_out want;
        if (rst_n && res_valid && res_ready) begin
            if (corner_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= PRINT_CAP) begin
                    $display("%0t ns: result expected none, got %h", $time, res_data);
                end
            end else begin
                want = corner_expected.pop_front();
                compare_field("valid_res", want.valid_res, res_data.valid_res);
                compare_field("center_col", want.center_col, res_data.center_col);
                compare_field("center_row", want.center_row, res_data.center_row);
                compare_field("corner_kind", want.corner_kind, res_data.corner_kind);
                compare_field("score", want.score, res_data.score);
                if (want.valid_res) begin
                    margin_seen++;
                end
                if (want.corner_kind == f9cs_pkg::KIND_BRIGHT) begin
                    bright_seen++;
                end
                if (want.corner_kind == f9cs_pkg::KIND_DARK) begin
                    dark_seen++;
                end
            end
        end
    end

    always @(posedge clk) begin : watchdog
        if ((pix_valid && pix_ready) || (res_valid && res_ready)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("tb: failure");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin : run_stimulus
        int t, w, h, n, f, frames, rand_pix;
        foreach (line_mem[i]) begin
            line_mem[i] = '0;
        end
        foreach (win[a, b]) begin
            win[a][b] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings; a second frame start lands in the middle of the line.
        new_scene(0, 0, 1'b1);
        queue_pixels(0, 0, 720, 12, 1'b1);
        queue_pixels(0, 0, 720, 8, 1'b1);
        settle();

        // Single-pixel spots give the largest bright and dark scores.
        apply_settings(0, 9, 9);
        new_scene(255, 0, 1'b0);
        add_rect(4, 4, 1, 1, 0);
        queue_pixels(0, 0, 9, 81, 1'b1);
        new_scene(0, 0, 1'b0);
        add_rect(4, 4, 1, 1, 255);
        queue_pixels(0, 0, 9, 81, 1'b1);
        settle();

        // Shrinking the width below the current column ends that line early.
        apply_settings(15, 14, 1024);
        random_scene(14, 13, 6);
        queue_pixels(0, 0, 14, 9 * 14 + 12, 1'b1);
        settle();
        write_reg(f9cs_pkg::CFG_WIDTH, 11'd9);
        end_writes();
        queue_pixels(9, 12, 13, 1, 1'b0);
        queue_pixels(10, 0, 9, 3 * 9, 1'b0);
        settle();

        rand_pix = 0;
        while (rand_pix < RANDOM_PIXELS) begin
            case ($urandom_range(0, 7))
                0: t = 0;
                1: t = 255;
                default: t = $urandom_range(3, 60);
            endcase
            w = $urandom_range(9, 16);
            h = $urandom_range(9, 14);
            apply_settings(t, w, h);
            frames = 1;
            for (f = 0; f < frames; f++) begin
                random_scene(w, h, 6);
                case ($urandom_range(0, 9))
                    0: n = $urandom_range(1, w * h - 1);
                    1: begin
                        scene_noise_only = 1'b1;
                        n = w * h;
                    end
                    default: n = w * (h + (($urandom_range(0, 3) == 0) ?
                        $urandom_range(1, 3) : 0));
                endcase
                queue_pixels(0, 0, w, n, 1'b1);
                rand_pix += n;
            end
            settle();
        end

        $display("Streamed %0d pixel transactions over %0d register settings.",
            pix_count, settings_used);
        $display("Results inside the border: %0d, bright corners %0d, dark corners %0d.",
            margin_seen, bright_seen, dark_seen);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: fast9_corner_score_stream_unit.f
hw/rtl/f9cs_pkg.sv
hw/rtl/f9cs_line_buf.sv
hw/rtl/f9cs_score.sv
hw/rtl/fast9_corner_score_stream_unit.sv
bench/tb_fast9_corner_score_stream_unit.sv
